@@ rtl/cbm_pkg.sv @@
// cbm_pkg: shared types and constants for the cartridge bank mapper
// no dependencies; imported by cbm_map_core and cartridge_bank_mapper
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

    // configuration register indexes
    localparam logic CFG_ROM_BANK_MASK = 1'b0;
    localparam logic CFG_EXTRAM_BYTES  = 1'b1;

    // bus access kind
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // result target codes
    typedef enum logic [1:0] {
        TGT_NONE  = 2'd0,
        TGT_ROM   = 2'd1,
        TGT_RAM   = 2'd2,
        TGT_FIXED = 2'd3
    } target_t;

    // fixed constants of the map
    localparam logic [7:0] RAM_ENABLE_KEY  = 8'h0A;
    localparam logic [7:0] FIXED_OPEN      = 8'hFF;
    localparam logic [7:0] FIXED_CLOCK     = 8'h00;
    localparam logic [6:0] ROM_BANK_BITS   = 7'h7F;
    localparam logic [5:0] RAM_MAX_PAGES   = 6'd32;
    localparam logic [15:0] RAM_WINDOW_BYTES = 16'd8192;

    // configuration registers as seen by the map logic
    typedef struct packed {
        logic [8:0]  rom_bank_mask;
        logic [15:0] extram_bytes;
    } cfg_t;

    // one bus access
    typedef struct packed {
        logic        command;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
    } access_t;

    // one mapping result
    typedef struct packed {
        target_t     target;
        logic [22:0] memory_address;
        logic        memory_write;
        logic [7:0]  write_byte;
        logic [7:0]  fixed_value;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/cartridge_bank_mapper.sv @@
// cartridge_bank_mapper: top level with stream ports, config registers and pipeline
// depends on cbm_pkg and cbm_map_core
// an access passes the input register, then the result register, to the master side
// throughput: one access per cycle unless m_tready stalls; set by the register pair
// reset: synchronous active-low aresetn clears both stages, rom_bank_mask to 1,
// extram_bytes to 0, and bank state to enable 0, rom bank 1, ram bank 0
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_mapper #(
    parameter int ROM_ADDRESS_BITS = 23
) (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration write channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_data,
    // access input
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // bus_address[15:0], bus_data[23:16]
    input  wire  [0:0]  s_tuser,   // command[0]
    // result output
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // memory_address[22:0], write_byte[30:23],
                                   // fixed_value[38:31], zero pad[39]
    output logic [2:0]  m_tuser    // target[1:0], memory_write[2]
);
    import cbm_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    access_t in_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t res;
    logic    advance;

    // configuration transactions are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rom_bank_mask <= 9'd1;
            cfg_reg.extram_bytes  <= 16'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ROM_BANK_MASK: cfg_reg.rom_bank_mask <= cfg_data[8:0];
                CFG_EXTRAM_BYTES:  cfg_reg.extram_bytes  <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.command     <= s_tuser[0];
            in_reg.bus_address <= s_tdata[15:0];
            in_reg.bus_data    <= s_tdata[23:16];
        end
    end

    cbm_map_core #(
        .ROM_ADDRESS_BITS(ROM_ADDRESS_BITS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cfg    (cfg_reg),
        .acc    (in_reg),
        .commit (in_valid_reg && advance),
        .res    (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.fixed_value, out_reg.write_byte, out_reg.memory_address};
    assign m_tuser  = {out_reg.memory_write, out_reg.target};

`ifndef SYNTHESIS
    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && advance |=> out_valid_reg)
        else $error("access left the input stage without reaching the result stage");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && in_valid_reg |-> advance)
        else $error("input stage would be overwritten while occupied");

    a_write_is_ram: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.memory_write |-> out_reg.target == TGT_RAM)
        else $error("memory write flagged on a non-ram target");
`endif

endmodule

`default_nettype wire

@@ rtl/cbm_map_core.sv @@
// cbm_map_core: bank state registers and the combinational address map
// depends on cbm_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbm_map_core #(
    parameter int ROM_ADDRESS_BITS = 23
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire cbm_pkg::cfg_t    cfg,
    input  wire cbm_pkg::access_t acc,
    input  wire                   commit,
    output cbm_pkg::result_t      res
);
    import cbm_pkg::*;

    localparam logic [22:0] ROM_MASK = 23'((64'd1 << ROM_ADDRESS_BITS) - 64'd1);

    logic [7:0] ram_enable_reg, ram_enable_next;
    logic [6:0] rom_bank_reg, rom_bank_next;
    logic [3:0] ram_bank_reg, ram_bank_next;

    logic [6:0]  bank_sel;
    logic [22:0] rom_addr;
    logic [5:0]  ram_pages;
    logic        in_ram_range;
    logic [12:0] ram_off;
    logic [22:0] ram_addr;
    logic [6:0]  data_bank;
    logic        ram_bank_ok;

    // address arithmetic
    always_comb begin
        bank_sel  = rom_bank_reg & cfg.rom_bank_mask[6:0];
        if (acc.bus_address[14]) begin
            rom_addr = {2'b00, bank_sel, acc.bus_address[13:0]};
        end else begin
            rom_addr = {7'd0, acc.bus_address};
        end
        rom_addr     = rom_addr & ROM_MASK;
        ram_off      = acc.bus_address[12:0];
        ram_pages    = (cfg.extram_bytes >= RAM_WINDOW_BYTES) ? RAM_MAX_PAGES
                                                              : {1'b0, cfg.extram_bytes[12:8]};
        in_ram_range = {1'b0, ram_off[12:8]} < ram_pages;
        ram_addr     = {6'd0, ram_bank_reg, ram_off};
        data_bank    = acc.bus_data[6:0] & ROM_BANK_BITS;
        ram_bank_ok  = (acc.bus_data <= 8'd3) || (acc.bus_data >= 8'd8 && acc.bus_data <= 8'd12);
    end

    // map decode and register writes
    always_comb begin
        res             = '0;
        res.target      = TGT_NONE;
        ram_enable_next = ram_enable_reg;
        rom_bank_next   = rom_bank_reg;
        ram_bank_next   = ram_bank_reg;
        if (!acc.bus_address[15]) begin
            if (acc.command == CMD_READ) begin
                res.target         = TGT_ROM;
                res.memory_address = rom_addr;
            end else begin
                case (acc.bus_address[14:13])
                    2'd0: begin
                        ram_enable_next = acc.bus_data;
                    end
                    2'd1: begin
                        rom_bank_next = (data_bank == 7'd0) ? 7'd1 : data_bank;
                    end
                    2'd2: begin
                        if (ram_bank_ok) begin
                            ram_bank_next = acc.bus_data[3:0];
                        end
                    end
                    default: begin
                        // mode select: no effect
                    end
                endcase
            end
        end else if (acc.bus_address[15:13] == 3'b101) begin
            if (ram_bank_reg[3]) begin
                // clock registers
                if (acc.command == CMD_READ) begin
                    res.target      = TGT_FIXED;
                    res.fixed_value = FIXED_CLOCK;
                end
            end else if (in_ram_range) begin
                if (acc.command == CMD_WRITE) begin
                    res.target         = TGT_RAM;
                    res.memory_address = ram_addr;
                    res.memory_write   = 1'b1;
                    res.write_byte     = acc.bus_data;
                end else if (ram_enable_reg == RAM_ENABLE_KEY) begin
                    res.target         = TGT_RAM;
                    res.memory_address = ram_addr;
                end else begin
                    res.target      = TGT_FIXED;
                    res.fixed_value = FIXED_OPEN;
                end
            end else if (acc.command == CMD_READ) begin
                res.target      = TGT_FIXED;
                res.fixed_value = FIXED_OPEN;
            end
        end
    end

    // bank state, updated when the access moves to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_enable_reg <= 8'd0;
            rom_bank_reg   <= 7'd1;
            ram_bank_reg   <= 4'd0;
        end else if (commit) begin
            ram_enable_reg <= ram_enable_next;
            rom_bank_reg   <= rom_bank_next;
            ram_bank_reg   <= ram_bank_next;
        end
    end

`ifndef SYNTHESIS
    a_rom_bank_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        rom_bank_reg != 7'd0)
        else $error("rom bank register holds zero");

    a_ram_bank_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_bank_reg <= 4'd3) || (ram_bank_reg >= 4'd8 && ram_bank_reg <= 4'd12))
        else $error("ram bank register holds an illegal value");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |=> $stable(rom_bank_reg) && $stable(ram_bank_reg) && $stable(ram_enable_reg))
        else $error("bank state changed without a committed access");
`endif

endmodule

`default_nettype wire
